/* src/wrd_pkg.sv */
// wrd_pkg: shared types, constants and calendar helpers for the workday return date block.
// Used by wrd_ctrl, wrd_dp and workday_return_date. No dependencies.
package wrd_pkg;

  // Field widths
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int VAC_W  = 12;
  localparam int WD_W   = 3;
  localparam int ERR_W  = 2;
  localparam int MASK_W = 7;

  // Packed channel widths (rounded up to whole bytes)
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam int DEF_MAX_VACATION_DAYS = 4095;

  localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;   // Friday and Saturday off
  localparam logic [MASK_W-1:0] ALL_DAYS   = 7'h7f;
  localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd9999;
  localparam logic [MON_W-1:0]  DEC        = 4'd12;
  localparam logic [WD_W-1:0]   SATURDAY   = 3'd6;

  // Reciprocals for constant division: y/100 and s/7
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int          SHIFT100 = 19;
  localparam logic [13:0] RECIP7   = 14'd9363;
  localparam int          SHIFT7   = 16;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DATE     = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_MASK     = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q100,
    ST_CHECK,
    ST_WSUM,
    ST_WMOD,
    ST_SKIP_PRE,
    ST_WORK,
    ST_SKIP_POST,
    ST_FINISH
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic q100;
    logic check;
    logic wsum;
    logic wmod;
    logic step;
    logic count;
    logic set_err;
    err_t err;
    logic emit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic invalid;
    logic mask_full;
    logic off_day;
    logic last_day;
    logic work_done;
    logic out_free;
  } sts_t;

  // Length of month m; 0 for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                               n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:            n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      default:                            n = 5'd0;
    endcase
    return n;
  endfunction

  // floor(31*mm/12) with mm the March-based month index
  function automatic logic [DAY_W-1:0] month_term(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] t;
    case (m)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

/* src/wrd_ctrl.sv */
// wrd_ctrl: sequencer for the workday return date block.
// Depends on wrd_pkg; drives wrd_dp through cmd_t, watches sts_t.
module wrd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wrd_pkg::sts_t sts,
  output wrd_pkg::cmd_t cmd
);
  import wrd_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_Q100;
      ST_Q100:      state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.invalid || sts.mask_full) state_nxt = ST_FINISH;
        else                              state_nxt = ST_WSUM;
      end
      ST_WSUM:      state_nxt = ST_WMOD;
      ST_WMOD:      state_nxt = ST_SKIP_PRE;
      ST_SKIP_PRE: begin
        if (!sts.off_day)      state_nxt = ST_WORK;
        else if (sts.last_day) state_nxt = ST_FINISH;
      end
      ST_WORK: begin
        if (sts.work_done)     state_nxt = ST_SKIP_POST;
        else if (sts.last_day) state_nxt = ST_FINISH;
      end
      ST_SKIP_POST: begin
        if (!sts.off_day || sts.last_day) state_nxt = ST_FINISH;
      end
      ST_FINISH:    if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    cmd.err   = ERR_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_Q100:  cmd.q100 = 1'b1;
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.invalid) begin
          cmd.set_err = 1'b1;
          cmd.err     = ERR_DATE;
        end else if (sts.mask_full) begin
          cmd.set_err = 1'b1;
          cmd.err     = ERR_MASK;
        end
      end
      ST_WSUM:  cmd.wsum = 1'b1;
      ST_WMOD:  cmd.wmod = 1'b1;
      ST_SKIP_PRE, ST_SKIP_POST: begin
        if (sts.off_day) begin
          if (sts.last_day) begin
            cmd.set_err = 1'b1;
            cmd.err     = ERR_OVERFLOW;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_WORK: begin
        if (!sts.work_done) begin
          cmd.count = !sts.off_day;
          if (sts.last_day) begin
            cmd.set_err = 1'b1;
            cmd.err     = ERR_OVERFLOW;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_FINISH: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* src/wrd_dp.sv */
// wrd_dp: date registers, weekday arithmetic, day stepper and output register.
// Depends on wrd_pkg; commanded by wrd_ctrl.
module wrd_dp #(
  parameter int MAX_VACATION_DAYS = wrd_pkg::DEF_MAX_VACATION_DAYS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [wrd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           cfg_we,
  input  logic [wrd_pkg::MASK_W-1:0]     cfg_wdata,
  input  wrd_pkg::cmd_t                  cmd,
  output wrd_pkg::sts_t                  sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wrd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [wrd_pkg::ERR_W-1:0]      out_tuser
);
  import wrd_pkg::*;

  // Control registers
  logic [MASK_W-1:0] mask_r;
  logic              out_valid_r, out_valid_nxt;

  // Working registers
  logic [DAY_W-1:0]  d_r, d_nxt;
  logic [MON_W-1:0]  m_r, m_nxt;
  logic [YEAR_W-1:0] y_r, y_nxt;
  logic [VAC_W-1:0]  vac_r, vac_nxt;
  logic [VAC_W-1:0]  worked_r, worked_nxt;
  logic [WD_W-1:0]   wd_r, wd_nxt;
  logic [7:0]        q100_r, q100_nxt;
  logic [6:0]        r100_r, r100_nxt;
  logic [1:0]        mod4_r, mod4_nxt;
  logic [1:0]        cmod4_r, cmod4_nxt;
  logic [14:0]       sum_r, sum_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;

  // Output registers
  logic [DAY_W-1:0]  od_r, od_nxt;
  logic [MON_W-1:0]  om_r, om_nxt;
  logic [YEAR_W-1:0] oy_r, oy_nxt;
  logic [WD_W-1:0]   owd_r, owd_nxt;
  logic [ERR_W-1:0]  oerr_r, oerr_nxt;

  // Input beat unpack
  logic [DAY_W-1:0]  in_day;
  logic [MON_W-1:0]  in_mon;
  logic [YEAR_W-1:0] in_year;
  logic [VAC_W-1:0]  in_vac;
  assign in_day  = in_tdata[4:0];
  assign in_mon  = in_tdata[8:5];
  assign in_year = in_tdata[22:9];
  assign in_vac  = in_tdata[34:23];

  // Saturate vacation length
  logic [VAC_W-1:0] vac_sat;
  always_comb begin
    if (32'(in_vac) > 32'(MAX_VACATION_DAYS)) vac_sat = VAC_W'(MAX_VACATION_DAYS);
    else                                      vac_sat = in_vac;
  end

  // y / 100 by reciprocal multiply
  logic [26:0] prod100;
  assign prod100 = 27'(y_r) * 27'(RECIP100);

  // Remainder and leap flag from the registered quotient (check cycle)
  logic [13:0]      r100_full;
  logic             leap_chk;
  logic [DAY_W-1:0] dim_chk;
  logic             invalid;
  assign r100_full = y_r - 14'(({6'd0, q100_r} << 6) + ({6'd0, q100_r} << 5)
                              + ({6'd0, q100_r} << 2));
  assign leap_chk  = (r100_full == 14'd0) ? (q100_r[1:0] == 2'd0) : (y_r[1:0] == 2'd0);
  assign dim_chk   = month_days(m_r, leap_chk);
  assign invalid   = (d_r == '0) || (m_r == '0) || (m_r > DEC) || (y_r == '0)
                     || (y_r > YEAR_LIMIT) || (d_r > dim_chk);

  // Weekday sum: d + yy + yy/4 - yy/100 + yy/400 + 31*mm/12
  logic              jan_feb;
  logic [YEAR_W-1:0] yy;
  logic [7:0]        qyy;
  logic [14:0]       sum_c;
  assign jan_feb = (m_r <= 4'd2);
  assign yy      = y_r - YEAR_W'(jan_feb);
  assign qyy     = (jan_feb && r100_r == 7'd0) ? q100_r - 8'd1 : q100_r;
  assign sum_c   = 15'(d_r) + 15'(yy) + 15'(yy >> 2) - 15'(qyy) + 15'(qyy >> 2)
                   + 15'(month_term(m_r));

  // sum mod 7 by reciprocal multiply
  logic [28:0] prod7;
  logic [12:0] q7;
  logic [15:0] q7x7;
  logic [15:0] rem7;
  assign prod7 = 29'(sum_r) * 29'(RECIP7);
  assign q7    = prod7[28:SHIFT7];
  assign q7x7  = (16'(q7) << 3) - 16'(q7);
  assign rem7  = 16'(sum_r) - q7x7;

  // Calendar state of the walk
  logic             leap_cur;
  logic [DAY_W-1:0] dim_cur;
  logic             month_end;
  logic [7:0]       mask_ext;
  assign leap_cur  = (r100_r == 7'd0) ? (cmod4_r == 2'd0) : (mod4_r == 2'd0);
  assign dim_cur   = month_days(m_r, leap_cur);
  assign month_end = (d_r >= dim_cur);
  assign mask_ext  = {1'b0, mask_r};

  // Status
  always_comb begin
    sts.invalid   = invalid;
    sts.mask_full = (mask_r == ALL_DAYS);
    sts.off_day   = mask_ext[wd_r];
    sts.last_day  = month_end && (m_r >= DEC) && (y_r >= YEAR_LIMIT);
    sts.work_done = (worked_r >= vac_r);
    sts.out_free  = !out_valid_r || out_tready;
  end

  // Next values of the working registers
  always_comb begin
    d_nxt      = d_r;
    m_nxt      = m_r;
    y_nxt      = y_r;
    vac_nxt    = vac_r;
    worked_nxt = worked_r;
    wd_nxt     = wd_r;
    q100_nxt   = q100_r;
    r100_nxt   = r100_r;
    mod4_nxt   = mod4_r;
    cmod4_nxt  = cmod4_r;
    sum_nxt    = sum_r;
    err_nxt    = err_r;

    if (cmd.load) begin
      d_nxt      = in_day;
      m_nxt      = in_mon;
      y_nxt      = in_year;
      vac_nxt    = vac_sat;
      worked_nxt = '0;
      err_nxt    = ERR_NONE;
    end
    if (cmd.q100) q100_nxt = prod100[26:SHIFT100];
    if (cmd.check) begin
      r100_nxt  = r100_full[6:0];
      mod4_nxt  = y_r[1:0];
      cmod4_nxt = q100_r[1:0];
    end
    if (cmd.wsum) sum_nxt = sum_c;
    if (cmd.wmod) wd_nxt  = rem7[2:0];
    if (cmd.count) worked_nxt = worked_r + VAC_W'(1);

    // One calendar day forward
    if (cmd.step) begin
      wd_nxt = (wd_r >= SATURDAY) ? '0 : wd_r + 3'd1;
      if (month_end) begin
        d_nxt = 5'd1;
        if (m_r >= DEC) begin
          m_nxt    = 4'd1;
          y_nxt    = y_r + 14'd1;
          mod4_nxt = mod4_r + 2'd1;
          if (r100_r >= 7'd99) begin
            r100_nxt  = '0;
            cmod4_nxt = cmod4_r + 2'd1;
          end else begin
            r100_nxt = r100_r + 7'd1;
          end
        end else begin
          m_nxt = m_r + 4'd1;
        end
      end else begin
        d_nxt = d_r + 5'd1;
      end
    end
    if (cmd.set_err) err_nxt = cmd.err;
  end

  // Output register
  always_comb begin
    od_nxt        = od_r;
    om_nxt        = om_r;
    oy_nxt        = oy_r;
    owd_nxt       = owd_r;
    oerr_nxt      = oerr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      oerr_nxt      = err_r;
      if (err_r != ERR_NONE) begin
        od_nxt  = '0;
        om_nxt  = '0;
        oy_nxt  = '0;
        owd_nxt = '0;
      end else begin
        od_nxt  = d_r;
        om_nxt  = m_r;
        oy_nxt  = y_r;
        owd_nxt = wd_r;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mask_r <= cfg_wdata;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    d_r      <= d_nxt;
    m_r      <= m_nxt;
    y_r      <= y_nxt;
    vac_r    <= vac_nxt;
    worked_r <= worked_nxt;
    wd_r     <= wd_nxt;
    q100_r   <= q100_nxt;
    r100_r   <= r100_nxt;
    mod4_r   <= mod4_nxt;
    cmod4_r  <= cmod4_nxt;
    sum_r    <= sum_nxt;
    err_r    <= err_nxt;
    od_r     <= od_nxt;
    om_r     <= om_nxt;
    oy_r     <= oy_nxt;
    owd_r    <= owd_nxt;
    oerr_r   <= oerr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, owd_r, oy_r, om_r, od_r};
  assign out_tuser  = oerr_r;

endmodule

/* src/workday_return_date.sv */
// workday_return_date: top level, joins the sequencer and the datapath.
// Depends on wrd_pkg, wrd_ctrl and wrd_dp.
//
//   channel  dir  width  contents
//   in_      in   40     start date and working-day count, one beat per request
//   out_     out  32+2   return date and weekday, error code in tuser
//   cfg_     in   7      weekend mask, written when cfg_we is high
//
// One request at a time: accepted in idle, then four setup steps (quotient, date
// check, weekday sum, weekday remainder), a walk by the day stepper in three phases
// (skip leading off days, count working days, skip trailing off days) and a final
// step that loads the output. The mask sets the length of the walk. Reset (rst_n low,
// synchronous) clears the sequencer and output valid and restores the Friday/Saturday
// mask. A stalled out_ beat holds; the next in_ beat is taken while it waits.
module workday_return_date #(
  parameter int MAX_VACATION_DAYS = wrd_pkg::DEF_MAX_VACATION_DAYS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year, [34:23] vacation_days
  input  logic [wrd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [4:0] return_day, [8:5] return_month, [22:9] return_year, [25:23] return_weekday
  output logic [wrd_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] error_code
  output logic [wrd_pkg::ERR_W-1:0]      out_tuser,
  input  logic                           cfg_we,
  input  logic [wrd_pkg::MASK_W-1:0]     cfg_wdata
);
  import wrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  wrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  wrd_dp #(
    .MAX_VACATION_DAYS (MAX_VACATION_DAYS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* test/workday_return_date_tb.sv */
// Self-checking testbench for workday_return_date: directed and random leave requests
// under several weekend masks, results checked against a calendar walker held here.
// Depends on wrd_pkg and the workday_return_date RTL.
`timescale 1ns / 1ps

module workday_return_date_tb;
  import wrd_pkg::*;

  // One request beat, start_day in the lowest bits
  typedef struct packed {
    logic [VAC_W-1:0]  vac;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } leave_req_t;

  // One return date as carried on out_tdata / out_tuser
  typedef struct packed {
    err_t              err;
    logic [WD_W-1:0]   weekday;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } return_t;

  // Calendar position during the walk
  typedef struct packed {
    int d;
    int m;
    int y;
    int wd;
    bit past_end;
  } cal_day_t;

  localparam int REQ_W       = $bits(leave_req_t);
  localparam int CYCLE_LIMIT = 140 * 32000 * 4;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ERR_W-1:0]      out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [MASK_W-1:0]     cfg_wdata  = '0;

  leave_req_t        leave_queue[$];
  return_t           returns_due[$];
  logic [MASK_W-1:0] off_mask    = MASK_RESET;
  bit                calm        = 1'b0;
  int                n_issued    = 0;
  int                n_returned  = 0;
  int                n_mismatch  = 0;
  int                cycle_count = 0;

  workday_return_date u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- calendar

  function automatic int month_length(input int m, input int y);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    case (m)
      2:                      return leap ? 29 : 28;
      4, 6, 9, 11:            return 30;
      1, 3, 5, 7, 8, 10, 12:  return 31;
      default:                return 0;
    endcase
  endfunction

  // Sunday = 0; January and February count as months 11/12 of the prior year
  function automatic int day_of_week(input int d, input int m, input int y);
    int a, yy, mm;
    a  = (14 - m) / 12;
    yy = y - a;
    mm = m + 12 * a - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
  endfunction

  // Step one day; stepping off the last day of year 9999 sets past_end
  function automatic cal_day_t tomorrow(input cal_day_t c);
    cal_day_t n;
    n = c;
    if (c.d >= month_length(c.m, c.y)) begin
      n.d = 1;
      if (c.m >= 12) begin
        if (c.y >= YEAR_LIMIT) n.past_end = 1'b1;
        else begin
          n.m = 1;
          n.y = c.y + 1;
        end
      end else begin
        n.m = c.m + 1;
      end
    end else begin
      n.d = c.d + 1;
    end
    n.wd = (c.wd + 1) % 7;
    return n;
  endfunction

  // Expected return date for one request under the given weekend mask
  function automatic return_t compute_return_date(input leave_req_t rq,
                                                  input logic [MASK_W-1:0] mask);
    cal_day_t c;
    return_t  r;
    int       worked, vac;
    c   = '0;
    r   = '0;
    vac = int'(rq.vac);
    if (vac > DEF_MAX_VACATION_DAYS) vac = DEF_MAX_VACATION_DAYS;
    c.d = int'(rq.day);
    c.m = int'(rq.month);
    c.y = int'(rq.year);
    if (c.d == 0 || c.m < 1 || c.m > 12 || c.y == 0 || c.y > YEAR_LIMIT ||
        c.d > month_length(c.m, c.y)) begin
      r.err = ERR_DATE;
    end else if (mask == ALL_DAYS) begin
      r.err = ERR_MASK;
    end else begin
      c.wd = day_of_week(c.d, c.m, c.y);
      // leave starts on the first working day
      while (!c.past_end && mask[c.wd]) c = tomorrow(c);
      worked = 0;
      while (!c.past_end && worked < vac) begin
        if (!mask[c.wd]) worked++;
        c = tomorrow(c);
      end
      // back at work on the next working day
      while (!c.past_end && mask[c.wd]) c = tomorrow(c);
      if (c.past_end) begin
        r.err = ERR_OVERFLOW;
      end else begin
        r.err     = ERR_NONE;
        r.day     = DAY_W'(c.d);
        r.month   = MON_W'(c.m);
        r.year    = YEAR_W'(c.y);
        r.weekday = WD_W'(c.wd);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic leave_req_t make_leave(input int d, input int m, input int y,
                                            input int v);
    leave_req_t rq;
    rq.day   = DAY_W'(d);
    rq.month = MON_W'(m);
    rq.year  = YEAR_W'(y);
    rq.vac   = VAC_W'(v);
    return rq;
  endfunction

  // Mostly valid dates with short leave; some raw noise, a few long leaves
  function automatic leave_req_t random_leave();
    leave_req_t  rq;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      rq.day   = DAY_W'($urandom);
      rq.month = MON_W'($urandom);
      rq.year  = YEAR_W'($urandom);
      rq.vac   = VAC_W'($urandom);
      return rq;
    end
    rq.month = MON_W'($urandom_range(12, 1));
    pick     = $urandom_range(99);
    if (pick < 15)      rq.year = YEAR_W'($urandom_range(9999, 9990));
    else if (pick < 20) rq.year = YEAR_W'($urandom_range(5, 1));
    else                rq.year = YEAR_W'($urandom_range(9999, 1));
    rq.day = DAY_W'($urandom_range(month_length(int'(rq.month), int'(rq.year)), 1));
    pick   = $urandom_range(99);
    if (pick < 80)      rq.vac = VAC_W'($urandom_range(60));
    else if (pick < 95) rq.vac = VAC_W'($urandom_range(600));
    else                rq.vac = VAC_W'($urandom_range(4095));
    return rq;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 14);
  endfunction

  task automatic queue_leave(input leave_req_t rq);
    leave_queue.push_back(rq);
    n_issued++;
  endtask

  // Hold off until every issued request has returned, then let the block settle
  task automatic wait_drained();
    while (n_returned < n_issued) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    off_mask  = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic report_field(input string what, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      n_mismatch++;
    end
  endtask

  // ---------------------------------------------------------------- request driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        returns_due.push_back(compute_return_date(leave_req_t'(in_tdata[REQ_W-1:0]), off_mask));
      if (!in_tvalid || in_tready) begin
        if (leave_queue.size() != 0 && !take_break()) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_DATA_W - REQ_W){1'b0}}, leave_queue.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  always @(posedge clk) begin : watch_returns
    return_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.day     = out_tdata[4:0];
        got.month   = out_tdata[8:5];
        got.year    = out_tdata[22:9];
        got.weekday = out_tdata[25:23];
        got.err     = err_t'(out_tuser);
        n_returned++;
        if (returns_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, got %p",
                   $time, got);
          n_mismatch++;
        end else begin
          want = returns_due.pop_front();
          report_field("error_code", want.err, got.err);
          report_field("return_day", want.day, got.day);
          report_field("return_month", want.month, got.month);
          report_field("return_year", want.year, got.year);
          report_field("return_weekday", want.weekday, got.weekday);
        end
      end
      out_tready <= !take_break();
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d of %0d results returned", $time, n_returned, n_issued);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin : run_test
    logic [MASK_W-1:0] fixed_masks [4];
    logic [MASK_W-1:0] mask_v;
    int                n_items;
    fixed_masks = '{7'h00, ALL_DAYS, 7'h7e, 7'h41};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass under the reset mask (Friday and Saturday off)
    queue_leave(make_leave(0, 1, 2024, 5));        // day zero
    queue_leave(make_leave(1, 0, 2024, 5));        // month zero
    queue_leave(make_leave(1, 13, 2024, 5));       // month past December
    queue_leave(make_leave(31, 15, 16383, 4095));  // every field all ones
    queue_leave(make_leave(1, 1, 0, 3));           // year zero
    queue_leave(make_leave(1, 1, 10000, 3));       // year past 9999
    queue_leave(make_leave(29, 2, 1900, 3));       // century, not leap
    queue_leave(make_leave(29, 2, 2000, 3));       // 400-year leap
    queue_leave(make_leave(29, 2, 2023, 3));       // common year
    queue_leave(make_leave(31, 4, 2021, 3));       // day beyond month end
    queue_leave(make_leave(1, 1, 1, 0));           // earliest date
    queue_leave(make_leave(15, 6, 2023, 0));       // working day, no leave
    queue_leave(make_leave(16, 6, 2023, 0));       // starts on a weekend day
    queue_leave(make_leave(31, 12, 9999, 0));      // last date, weekend skip overflows
    queue_leave(make_leave(20, 12, 9999, 30));     // walk overflows
    queue_leave(make_leave(1, 12, 9999, 10));      // just fits in the last year
    queue_leave(make_leave(1, 1, 2000, 4095));     // longest leave
    queue_leave(make_leave(28, 12, 2023, 5));      // year rollover
    queue_leave(make_leave(28, 2, 2024, 1));       // leap February end
    queue_leave(make_leave(28, 2, 2023, 1));       // common February end
    queue_leave(make_leave(31, 1, 2024, 1));       // month rollover
    wait_drained();

    // Random phases, each under its own mask
    for (int ph = 0; ph < 8; ph++) begin
      mask_v  = (ph < 4) ? fixed_masks[ph] : MASK_W'($urandom_range(126));
      n_items = (ph == 0) ? 20 : 11;
      write_mask(mask_v);
      calm = (ph == 0);
      if (mask_v == ALL_DAYS) queue_leave(make_leave(30, 2, 2024, 7));  // date error wins
      repeat (n_items) queue_leave(random_leave());
      wait_drained();
    end
    calm = 1'b0;

    repeat (64) @(posedge clk);
    if (n_mismatch == 0 && returns_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
